// ===== rtl/pcm_pkg.sv =====
// Package for the packed cell memory: word types, command codes, store geometry
// and the queue entry that links the front and back parts.
// Depends on nothing; every other file but pcm_ram imports it.
package pcm_pkg;

	// Store geometry.
	localparam int STORE_WORDS = 4096;
	localparam int ADDR_W      = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
	localparam int DATA_W      = 64;

	// Depth of the queue between the front and back parts (a power of two).
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	// Configuration register indexes and reset values.
	localparam logic REG_CELL_WIDTH  = 1'b0;
	localparam logic REG_TAPE_LENGTH = 1'b1;
	localparam logic [1:0]  CELL_WIDTH_RESET  = 2'd0;
	localparam logic [15:0] TAPE_LENGTH_RESET = 16'd30000;

	typedef enum logic [1:0] {
		CMD_GET = 2'd0,
		CMD_SET = 2'd1,
		CMD_INC = 2'd2,
		CMD_DEC = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [15:0] cell_index;
		logic [63:0] write_value;
	} req_t;

	typedef struct packed {
		logic [63:0] cell_value;
		logic        range_error;
	} rsp_t;

	// One classified word as it waits between the two halves.
	typedef struct packed {
		cmd_t              cmd;
		logic              range_error;
		logic [ADDR_W-1:0] addr;
		logic [1:0]        width_sel;
		logic [2:0]        slot;
		logic [63:0]       write_value;
	} entry_t;

	// Status passed from the back part to the front part.
	typedef struct packed {
		logic clearing;
	} back_status_t;

	typedef enum logic [1:0] {
		BK_CLEAR = 2'd0,
		BK_IDLE  = 2'd1,
		BK_WAIT  = 2'd2
	} back_state_t;

endpackage

// ===== rtl/pcm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module pcm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/pcm_queue.sv =====
// Short queue of classified words between the front and back parts.
// Depends on pcm_pkg.
module pcm_queue
	import pcm_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	input  logic   pop,
	output entry_t head,
	output logic   empty,
	output logic   full
);

	entry_t            slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign head  = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// The producers must never overrun or underrun the queue.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("queue written while full");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue read while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QPTR_W+1)'(QUEUE_DEPTH))
		else $error("queue count beyond its depth");

endmodule

// ===== rtl/pcm_front.sv =====
// Front part: configuration registers, request acceptance and classification
// of each request into a store address, slot and range verdict.
// Depends on pcm_pkg.
module pcm_front
	import pcm_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	// Configuration port.
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	// Request channel.
	input  logic         req_valid,
	output logic         req_stall,
	input  req_t         req,
	// Towards the queue.
	output logic         push,
	output entry_t       push_entry,
	input  logic         queue_full,
	input  back_status_t back_status
);

	logic [1:0]  cell_width_sel_q;
	logic [15:0] tape_length_q;
	logic        cfg_write;
	logic        reg_sel;
	logic [15:0] word_idx;
	logic [16:0] word_wide;
	logic [2:0]  slot_mask;

	assign pready    = 1'b1;
	assign reg_sel   = paddr[2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_width_sel_q <= CELL_WIDTH_RESET;
			tape_length_q    <= TAPE_LENGTH_RESET;
		end else if (cfg_write) begin
			unique case (reg_sel)
				REG_CELL_WIDTH:  cell_width_sel_q <= pwdata[1:0];
				REG_TAPE_LENGTH: tape_length_q    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_sel)
			REG_CELL_WIDTH:  prdata = {30'd0, cell_width_sel_q};
			REG_TAPE_LENGTH: prdata = {16'd0, tape_length_q};
			default:         prdata = '0;
		endcase
	end

	// Requests wait while the queue is full or the store is being cleared.
	assign req_stall = queue_full || back_status.clearing;
	assign push      = req_valid && !req_stall;

	// Cells per word is 8 >> sel, so the word index is the cell index shifted
	// right by 3 - sel and the slot is the remaining low bits.
	assign word_idx  = req.cell_index >> (2'd3 - cell_width_sel_q);
	assign word_wide = {1'b0, word_idx};
	assign slot_mask = 3'(4'd8 >> cell_width_sel_q) - 3'd1;

	always_comb begin
		push_entry.cmd         = req.cmd;
		push_entry.range_error = (req.cell_index >= tape_length_q)
			|| (word_wide >= 17'(STORE_WORDS));
		push_entry.addr        = word_idx[ADDR_W-1:0];
		push_entry.width_sel   = cell_width_sel_q;
		push_entry.slot        = req.cell_index[2:0] & slot_mask;
		push_entry.write_value = req.write_value;
	end

endmodule

// ===== rtl/pcm_back.sv =====
// Back part: clearing pass after reset, read-modify-write of the word store
// and the response register.
// Depends on pcm_pkg and pcm_ram.
module pcm_back
	import pcm_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	// From the queue.
	input  entry_t       head,
	input  logic         queue_empty,
	output logic         pop,
	output back_status_t back_status,
	// Response channel.
	output logic         rsp_valid,
	input  logic         rsp_stall,
	output rsp_t         rsp
);

	back_state_t       state_q;
	back_state_t       state_d;
	logic [ADDR_W-1:0] clr_addr_q;
	logic              clr_last;
	entry_t            ent_s1;
	logic              rsp_valid_q;
	rsp_t              rsp_q;
	logic              out_free;
	logic              take_err;
	logic              take_rd;
	logic              load_ok;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic              ram_re;
	logic [DATA_W-1:0] ram_rdata;

	logic [8:0]        shift_wide;
	logic [5:0]        shift;
	logic [63:0]       mask;
	logic [63:0]       cur;
	logic [63:0]       nv;
	logic [63:0]       new_word;

	pcm_ram #(
		.WIDTH (DATA_W),
		.DEPTH (STORE_WORDS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (head.addr),
		.rdata (ram_rdata)
	);

	assign clr_last = (clr_addr_q == ADDR_W'(STORE_WORDS - 1));
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign take_err = (state_q == BK_IDLE) && !queue_empty && out_free && head.range_error;
	assign take_rd  = (state_q == BK_IDLE) && !queue_empty && out_free && !head.range_error;

	// Cell arithmetic on the word returned by the store.
	assign shift_wide = {3'd0, ent_s1.slot, 3'd0} << ent_s1.width_sel;
	assign shift      = shift_wide[5:0];

	always_comb begin
		unique case (ent_s1.width_sel)
			2'd0: mask = 64'h0000_0000_0000_00ff;
			2'd1: mask = 64'h0000_0000_0000_ffff;
			2'd2: mask = 64'h0000_0000_ffff_ffff;
			2'd3: mask = 64'hffff_ffff_ffff_ffff;
			default: mask = '0;
		endcase
	end

	assign cur = (ram_rdata >> shift) & mask;

	always_comb begin
		unique case (ent_s1.cmd)
			CMD_GET: nv = cur;
			CMD_SET: nv = ent_s1.write_value & mask;
			CMD_INC: nv = (cur + 64'd1) & mask;
			CMD_DEC: nv = (cur - 64'd1) & mask;
			default: nv = cur;
		endcase
	end

	assign new_word = (ram_rdata & ~(mask << shift)) | (nv << shift);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_CLEAR: if (clr_last) begin
				state_d = BK_IDLE;
			end
			BK_IDLE:  if (take_rd) begin
				state_d = BK_WAIT;
			end
			BK_WAIT:  state_d = BK_IDLE;
			default:  state_d = BK_CLEAR;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		pop       = 1'b0;
		ram_re    = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = ent_s1.addr;
		ram_wdata = new_word;
		load_ok   = 1'b0;
		unique case (state_q)
			BK_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_addr_q;
				ram_wdata = '0;
			end
			BK_IDLE: begin
				pop    = take_err || take_rd;
				ram_re = take_rd;
			end
			BK_WAIT: begin
				ram_we  = (ent_s1.cmd != CMD_GET);
				load_ok = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_CLEAR;
			clr_addr_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_CLEAR) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (load_ok || take_err) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_rd) begin
			ent_s1 <= head;
		end
		if (take_err) begin
			rsp_q.cell_value  <= '0;
			rsp_q.range_error <= 1'b1;
		end else if (load_ok) begin
			rsp_q.cell_value  <= nv;
			rsp_q.range_error <= 1'b0;
		end
	end

	assign rsp_valid            = rsp_valid_q;
	assign rsp                  = rsp_q;
	assign back_status.clearing = (state_q == BK_CLEAR);

	// A response is loaded in the wait state only into an empty register.
	a_wait_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_WAIT) |-> !rsp_valid_q)
		else $error("response register busy during store access");
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_CLEAR) |-> (!pop && !rsp_valid_q))
		else $error("word handled during clearing pass");
	a_read_then_wait: assert property (@(posedge clk) disable iff (!arst_n)
		take_rd |=> (state_q == BK_WAIT))
		else $error("store read not followed by its write-back cycle");

endmodule

// ===== rtl/packed_cell_memory.sv =====
// Top level of the packed cell memory: a store of 8/16/32/64-bit cells packed
// into 64-bit words, serving get, set, increment and decrement.
// Depends on pcm_pkg, pcm_front, pcm_queue and pcm_back (which holds pcm_ram).
//
//   Channel   Direction  Handshake                  Word
//   req       in         req_valid / req_stall      req_t: cmd, cell_index, write_value
//   rsp       out        rsp_valid / rsp_stall      rsp_t: cell_value, range_error
//   config    in         APB psel/penable/pready    cell_width_sel @0, tape_length @4
//
// An in-range word is read from the store in the idle state, then modified, written
// back and answered in the wait state; a word out of range is answered from the idle
// state. As the read is registered and the write-back must land before the next read,
// no word is taken in the wait state. After reset the store is cleared one word per
// cycle over all 4096 words; requests are stalled meanwhile, though configuration
// writes are taken. A stalled response holds in its register as the queue fills.
module packed_cell_memory
	import pcm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Request channel.
	input  logic        req_valid,
	output logic        req_stall,
	input  req_t        req,
	// Response channel.
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_t        rsp
);

	// The front part classifies each request as it is accepted, so the back
	// part never needs the configuration registers.
	logic         push;
	entry_t       push_entry;
	logic         pop;
	entry_t       head;
	logic         queue_empty;
	logic         queue_full;
	back_status_t back_status;

	pcm_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.push        (push),
		.push_entry  (push_entry),
		.queue_full  (queue_full),
		.back_status (back_status)
	);

	// The queue lets the front keep accepting words while the back part is
	// busy with the store or waiting for the response to be taken.
	pcm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.empty      (queue_empty),
		.full       (queue_full)
	);

	// The back part owns the store and the response register.
	pcm_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.queue_empty (queue_empty),
		.pop         (pop),
		.back_status (back_status),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp)
	);

endmodule
